// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked at every rising clock edge outside reset.
`define DPLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("dpls checker: property failed");

// Same check, stated as a condition that must hold whenever an enable is high.
`define DPLS_ASSERT_WHEN(label, clk, rst_n, en, cond) \
  `DPLS_ASSERT(label, clk, rst_n, (en) |-> (cond))

`endif

// ===== rtl/core/dpls_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth pyramid level select package
// Shared constants, status codes, chain summary type and a ceiling log2 helper.
// ----------------------------------------------------------------------------
package dpls_pkg;

  // Chain limits.
  localparam int MAX_EXTENT  = 16384;
  localparam int LEVEL_LIMIT = 16;

  // Field widths.
  localparam int SIDE_W   = 15;
  localparam int PROJ_W   = 16;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int TEXEL_W  = 29;
  localparam int PROD_W   = 2 * SIDE_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 72;

  localparam logic [TEXEL_W-1:0] TEXEL_MAX = '1;

  // Chain status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_LEVELS = 2'd3
  } chain_status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  // Chain builder sequencer states.
  typedef enum logic [1:0] {
    BLD_IDLE,
    BLD_CHECK,
    BLD_RUN,
    BLD_FINISH
  } build_state_e;

  // Chain summary handed from the builder to the query path.
  typedef struct packed {
    logic                chain_ok;
    chain_status_e       refusal;
    logic [COUNT_W-1:0]  levels;
    logic [TEXEL_W-1:0]  texels;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
  } chain_info_t;

  // Ceiling log2 of a 16-bit value: bit length of (m - 1); zero for m <= 1.
  function automatic logic [4:0] clog2_16(input logic [15:0] m);
    logic [15:0] v;
    logic [4:0]  res;
    v   = (m == 16'd0) ? 16'd0 : m - 16'd1;
    res = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        res = 5'(i + 1);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/depth_pyramid_level_select.sv =====
// ----------------------------------------------------------------------------
// Depth pyramid level select
// Derives a depth-pyramid chain from the display extent and answers queries.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   -------   ---------  ---------------------------------------------------
//   s_axis    in         projected_width, projected_height, level_index
//   m_axis    out        chain_status .. chain_texels, one per query
//   cfg       in         display_width (index 0), display_height (index 1)
//
// A query passes through the input register and then the result register,
// and queries stream at one per cycle while the result side keeps taking and
// the chain builder is idle. A register write starts the chain builder, which
// checks the extent and then sweeps one level per cycle through its multiplier
// before a finish state stores the chain; a refused extent ends at the check.
// s_axis_tready is low during a write and while the builder runs.
// After reset there is no chain and queries report a zero extent.
// A stalled result holds in the output register while one more query enters.
module depth_pyramid_level_select #(
  parameter int unsigned MaxExtent  = dpls_pkg::MAX_EXTENT,
  parameter int unsigned LevelLimit = dpls_pkg::LEVEL_LIMIT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [dpls_pkg::SIDE_W-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // projected_width[15:0], projected_height[31:16], level_index[35:32], zero fill
  input  logic [dpls_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // chain_status[1:0], selected_level[5:2], level_found[6], level_width[21:7],
  // level_height[36:22], level_count[41:37], chain_texels[70:42], zero fill
  output logic [dpls_pkg::OUT_W-1:0]    m_axis_tdata
);
  import dpls_pkg::*;

  chain_info_t info;
  logic        busy;
  logic        hold;

  // Queries wait while a write lands or the chain is being derived.
  assign hold = busy || cfg_we_i;

  dpls_chain_builder #(
    .MaxExtent  (MaxExtent),
    .LevelLimit (LevelLimit)
  ) u_builder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .info_o      (info)
  );

  dpls_query u_query (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (hold),
    .info_i      (info),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .proj_w_i    (s_axis_tdata[PROJ_W-1:0]),
    .proj_h_i    (s_axis_tdata[2*PROJ_W-1:PROJ_W]),
    .level_idx_i (s_axis_tdata[2*PROJ_W+IDX_W-1:2*PROJ_W]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

// ===== rtl/core/dpls_chain_builder.sv =====
// ----------------------------------------------------------------------------
// Depth pyramid chain builder
// Holds the display extent and derives status, level count and texel total.
// ----------------------------------------------------------------------------
module dpls_chain_builder #(
  parameter int unsigned MaxExtent  = dpls_pkg::MAX_EXTENT,
  parameter int unsigned LevelLimit = dpls_pkg::LEVEL_LIMIT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_index_i,
  input  logic [dpls_pkg::SIDE_W-1:0]     cfg_data_i,
  output logic                            busy_o,
  output dpls_pkg::chain_info_t           info_o
);
  import dpls_pkg::*;

  build_state_e          state_q, state_d;
  logic [SIDE_W-1:0]     disp_w_q, disp_w_d;
  logic [SIDE_W-1:0]     disp_h_q, disp_h_d;
  logic [SIDE_W-1:0]     run_w_q, run_w_d;
  logic [SIDE_W-1:0]     run_h_q, run_h_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      last_q, last_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic                  chain_ok_q, chain_ok_d;
  chain_status_e         refusal_q, refusal_d;
  logic [COUNT_W-1:0]    levels_q, levels_d;
  logic [TEXEL_W-1:0]    texels_q, texels_d;

  logic [15:0]           side_max;
  logic [4:0]            side_log;
  logic                  is_zero;
  logic                  is_above;
  logic                  too_many;
  logic [SUM_W-1:0]      total;

  // Refusal checks on the stored extent; levels needed is clog2(max side) + 1.
  always_comb begin
    side_max = (disp_w_q > disp_h_q) ? {1'b0, disp_w_q} : {1'b0, disp_h_q};
    side_log = clog2_16(side_max);
    is_zero  = (disp_w_q == '0) || (disp_h_q == '0);
    is_above = ({2'b00, disp_w_q} > 17'(MaxExtent)) ||
               ({2'b00, disp_h_q} > 17'(MaxExtent));
    too_many = ({1'b0, side_log} + 6'd1) > 6'(LevelLimit);
    total    = sum_q + SUM_W'(prod_q);
  end

  // Next state of the sequencer; a register write always restarts the check.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BLD_IDLE:   state_d = BLD_IDLE;
      BLD_CHECK: begin
        state_d = (is_zero || is_above || too_many) ? BLD_IDLE : BLD_RUN;
      end
      BLD_RUN: begin
        if (cnt_q == last_q) begin
          state_d = BLD_FINISH;
        end
      end
      BLD_FINISH: state_d = BLD_IDLE;
      default:    state_d = BLD_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = BLD_CHECK;
    end
  end

  // Datapath: one level per cycle, product registered before it is summed.
  always_comb begin
    disp_w_d   = disp_w_q;
    disp_h_d   = disp_h_q;
    run_w_d    = run_w_q;
    run_h_d    = run_h_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    prod_d     = prod_q;
    sum_d      = sum_q;
    chain_ok_d = chain_ok_q;
    refusal_d  = refusal_q;
    levels_d   = levels_q;
    texels_d   = texels_q;
    case (state_q)
      BLD_CHECK: begin
        if (is_zero || is_above || too_many) begin
          chain_ok_d = 1'b0;
          levels_d   = '0;
          texels_d   = '0;
          refusal_d  = is_zero ? ST_ZERO : (is_above ? ST_ABOVE : ST_LEVELS);
        end else begin
          run_w_d = disp_w_q;
          run_h_d = disp_h_q;
          cnt_d   = '0;
          last_d  = side_log[IDX_W-1:0];
          sum_d   = '0;
        end
      end
      BLD_RUN: begin
        prod_d  = PROD_W'(run_w_q) * PROD_W'(run_h_q);
        run_w_d = (run_w_q > SIDE_W'(1)) ? SIDE_W'((16'(run_w_q) + 16'd1) >> 1) : run_w_q;
        run_h_d = (run_h_q > SIDE_W'(1)) ? SIDE_W'((16'(run_h_q) + 16'd1) >> 1) : run_h_q;
        if (cnt_q != '0) begin
          sum_d = total;
        end
        cnt_d = cnt_q + IDX_W'(1);
      end
      BLD_FINISH: begin
        chain_ok_d = 1'b1;
        refusal_d  = ST_OK;
        levels_d   = COUNT_W'(last_q) + COUNT_W'(1);
        texels_d   = (total > SUM_W'(TEXEL_MAX)) ? TEXEL_MAX : total[TEXEL_W-1:0];
      end
      default: ;
    endcase
    // Register writes; the index is one bit wide, so every index is a register.
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:  disp_w_d = cfg_data_i;
        REG_HEIGHT: disp_h_d = cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Control and chain state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BLD_IDLE;
      disp_w_q   <= '0;
      disp_h_q   <= '0;
      cnt_q      <= '0;
      chain_ok_q <= 1'b0;
      refusal_q  <= ST_ZERO;
      levels_q   <= '0;
      texels_q   <= '0;
    end else begin
      state_q    <= state_d;
      disp_w_q   <= disp_w_d;
      disp_h_q   <= disp_h_d;
      cnt_q      <= cnt_d;
      chain_ok_q <= chain_ok_d;
      refusal_q  <= refusal_d;
      levels_q   <= levels_d;
      texels_q   <= texels_d;
    end
  end

  // Working registers of the level sweep.
  always_ff @(posedge clk_i) begin
    run_w_q <= run_w_d;
    run_h_q <= run_h_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    sum_q   <= sum_d;
  end

  // Outputs.
  always_comb begin
    busy_o          = (state_q != BLD_IDLE);
    info_o.chain_ok = chain_ok_q;
    info_o.refusal  = refusal_q;
    info_o.levels   = levels_q;
    info_o.texels   = texels_q;
    info_o.width    = disp_w_q;
    info_o.height   = disp_h_q;
  end

endmodule

// ===== rtl/core/dpls_query.sv =====
// ----------------------------------------------------------------------------
// Depth pyramid query path
// Input register, level selection and level size logic, result register.
// ----------------------------------------------------------------------------
module dpls_query (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          hold_i,
  input  dpls_pkg::chain_info_t         info_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [dpls_pkg::PROJ_W-1:0]   proj_w_i,
  input  logic [dpls_pkg::PROJ_W-1:0]   proj_h_i,
  input  logic [dpls_pkg::IDX_W-1:0]    level_idx_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [dpls_pkg::OUT_W-1:0]    m_data_o
);
  import dpls_pkg::*;

  logic                  v1_q, v1_d;
  logic                  v2_q, v2_d;
  logic [PROJ_W-1:0]     pw_q;
  logic [PROJ_W-1:0]     ph_q;
  logic [IDX_W-1:0]      idx_q;
  logic [OUT_W-1:0]      res_q;
  logic [OUT_W-1:0]      res_d;
  logic                  adv1;
  logic                  adv2;

  logic [PROJ_W-1:0]     proj_max;
  logic [4:0]            proj_log;
  logic [IDX_W-1:0]      want;
  logic [COUNT_W-1:0]    coarsest;
  logic [COUNT_W-1:0]    clamp;
  logic [IDX_W-1:0]      sel;
  logic                  have_chain;
  logic                  found;
  logic [SIDE_W:0]       round_mask;
  logic [SIDE_W:0]       lw_wide;
  logic [SIDE_W:0]       lh_wide;
  logic [SIDE_W-1:0]     lw;
  logic [SIDE_W-1:0]     lh;
  chain_status_e         status;

  // Two-stage handshake: each stage loads when it is empty or moves on.
  always_comb begin
    adv2      = !v2_q || m_ready_i;
    adv1      = !v1_q || adv2;
    s_ready_o = adv1 && !hold_i;
    v1_d      = adv1 ? (s_valid_i && s_ready_o) : v1_q;
    v2_d      = adv2 ? v1_q : v2_q;
  end

  // Level selection: smallest s with max extent <= 2^(s+1), clamped.
  always_comb begin
    proj_max   = (pw_q > ph_q) ? pw_q : ph_q;
    proj_log   = clog2_16(proj_max);
    want       = (proj_max <= PROJ_W'(2)) ? '0 : IDX_W'(proj_log - 5'd1);
    have_chain = info_i.chain_ok && (info_i.levels != '0);
    coarsest   = info_i.levels - COUNT_W'(1);
    clamp      = (COUNT_W'(want) < coarsest) ? COUNT_W'(want) : coarsest;
    if (!have_chain) begin
      sel = '0;
    end else if (clamp > COUNT_W'(15)) begin
      sel = '1;
    end else begin
      sel = clamp[IDX_W-1:0];
    end
  end

  // Queried level size: ceiling shift of the display extent by the index.
  always_comb begin
    found      = have_chain && (COUNT_W'(idx_q) < info_i.levels);
    round_mask = ((SIDE_W+1)'(1) << idx_q) - (SIDE_W+1)'(1);
    lw_wide    = ({1'b0, info_i.width} + round_mask) >> idx_q;
    lh_wide    = ({1'b0, info_i.height} + round_mask) >> idx_q;
    lw         = found ? lw_wide[SIDE_W-1:0] : '0;
    lh         = found ? lh_wide[SIDE_W-1:0] : '0;
    status     = info_i.chain_ok ? ST_OK : info_i.refusal;
    res_d      = {1'b0, info_i.texels, info_i.levels, lh, lw, found, sel, status};
  end

  // Handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      pw_q  <= proj_w_i;
      ph_q  <= proj_h_i;
      idx_q <= level_idx_i;
    end
    if (adv2) begin
      res_q <= res_d;
    end
  end

  assign m_valid_o = v2_q;
  assign m_data_o  = res_q;

endmodule

// ===== rtl/core/dpls_checker.sv =====
// ----------------------------------------------------------------------------
// Depth pyramid level select checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpls_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [dpls_pkg::OUT_W-1:0]    m_axis_tdata
);
  import dpls_pkg::*;

  logic [1:0]         status;
  logic [IDX_W-1:0]   sel;
  logic               found;
  logic [COUNT_W-1:0] count;
  logic [TEXEL_W-1:0] texels;

  assign status = m_axis_tdata[1:0];
  assign sel    = m_axis_tdata[5:2];
  assign found  = m_axis_tdata[6];
  assign count  = m_axis_tdata[41:37];
  assign texels = m_axis_tdata[70:42];

  // A stalled result stays put.
  `DPLS_ASSERT(a_hold_result, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // A write blocks queries in its own cycle and while the chain is derived.
  `DPLS_ASSERT(a_write_blocks, clk_i, rst_ni,
    cfg_we_i |-> (!s_axis_tready ##1 !s_axis_tready))

  // A refused chain reports no levels, no texels and level zero.
  `DPLS_ASSERT_WHEN(a_refused_empty, clk_i, rst_ni,
    m_axis_tvalid && (status != ST_OK),
    (count == '0) && (texels == '0) && (sel == '0) && !found)

  // A found level needs a chain and a selected level inside it.
  `DPLS_ASSERT_WHEN(a_found_in_chain, clk_i, rst_ni,
    m_axis_tvalid && found,
    (status == ST_OK) && (count != '0) && (COUNT_W'(sel) < count))

endmodule

bind depth_pyramid_level_select dpls_checker u_dpls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/depth_pyramid_level_select_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pyramid level select testbench
// Writes a series of display extents, from refused ones to the largest chain,
// and streams level queries against each. A local chain model predicts the
// results not typed by a probe; a scoreboard checks each field by field.
// ----------------------------------------------------------------------------
module depth_pyramid_level_select_tb;
  import dpls_pkg::*;

  // One level query, packed as it travels on s_axis_tdata.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PROJ_W-1:0] ph;
    logic [PROJ_W-1:0] pw;
  } level_query_t;

  // One result, packed as it travels on m_axis_tdata (zero fill left out).
  typedef struct packed {
    logic [TEXEL_W-1:0] texels;
    logic [COUNT_W-1:0] count;
    logic [SIDE_W-1:0]  height;
    logic [SIDE_W-1:0]  width;
    logic               found;
    logic [3:0]         sel;
    chain_status_e      status;
  } level_result_t;

  // Directed probe: an optional new extent, a query and an optional typed result.
  typedef struct {
    bit            set_extent;
    logic [14:0]   ext_w;
    logic [14:0]   ext_h;
    level_query_t  q;
    bit            typed;
    level_result_t want;
  } probe_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_index_i = REG_WIDTH;
  logic [SIDE_W-1:0] cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // projected_width[15:0], projected_height[31:16], level_index[35:32], zero fill
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // chain_status[1:0], selected_level[5:2], level_found[6], level_width[21:7],
  // level_height[36:22], level_count[41:37], chain_texels[70:42], zero fill
  logic [OUT_W-1:0]  m_axis_tdata;

  depth_pyramid_level_select i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Chain model state, updated on every register write.
  logic [SIDE_W-1:0]  disp_w = '0;
  logic [SIDE_W-1:0]  disp_h = '0;
  bit                 chain_ok = 1'b0;
  logic [COUNT_W-1:0] chain_levels = '0;
  logic [TEXEL_W-1:0] chain_texels = '0;
  chain_status_e      chain_refusal = ST_ZERO;

  level_result_t pending_results[$];
  int unsigned   fail_count = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  probe_row_t    probe_rows[$];

  function automatic int unsigned halve_up(input int unsigned v);
    return (v > 1) ? (v + 1) / 2 : v;
  endfunction

  // Derive the chain from the current display extent.
  function automatic void rebuild_chain();
    int unsigned       w;
    int unsigned       h;
    int unsigned       n;
    longint unsigned   sum;
    w   = disp_w;
    h   = disp_h;
    n   = 0;
    sum = 0;
    chain_ok     = 1'b0;
    chain_levels = '0;
    chain_texels = '0;
    if (w == 0 || h == 0) begin
      chain_refusal = ST_ZERO;
      return;
    end
    if (w > MAX_EXTENT || h > MAX_EXTENT) begin
      chain_refusal = ST_ABOVE;
      return;
    end
    forever begin
      if (n >= LEVEL_LIMIT) begin
        chain_refusal = ST_LEVELS;
        return;
      end
      n++;
      sum += longint'(w) * longint'(h);
      if (w == 1 && h == 1) break;
      w = halve_up(w);
      h = halve_up(h);
    end
    chain_ok      = 1'b1;
    chain_levels  = COUNT_W'(n);
    chain_texels  = (sum > TEXEL_MAX) ? TEXEL_MAX : TEXEL_W'(sum);
    chain_refusal = ST_OK;
  endfunction

  // Expected answer to one query against the current chain.
  function automatic level_result_t predict_level(input level_query_t q);
    level_result_t r;
    int unsigned   px;
    int unsigned   py;
    int unsigned   sel;
    int unsigned   lw;
    int unsigned   lh;
    r   = '0;
    px  = q.pw;
    py  = q.ph;
    sel = 0;
    lw  = 0;
    lh  = 0;
    if (chain_ok && chain_levels > 0) begin
      // Halve the projected extent until it spans two by two or the chain ends.
      while ((px > 2 || py > 2) && sel < chain_levels - 1) begin
        px = (px + 1) / 2;
        py = (py + 1) / 2;
        sel++;
      end
      if (sel > 15) sel = 15;
      if (q.idx < chain_levels) begin
        r.found = 1'b1;
        lw = disp_w;
        lh = disp_h;
        for (int k = 0; k < q.idx; k++) begin
          lw = halve_up(lw);
          lh = halve_up(lh);
        end
      end
    end
    r.status = chain_ok ? ST_OK : chain_refusal;
    r.sel    = 4'(sel);
    r.width  = SIDE_W'(lw);
    r.height = SIDE_W'(lh);
    r.count  = chain_levels;
    r.texels = chain_texels;
    return r;
  endfunction

  function automatic level_result_t typed_result(input chain_status_e status,
                                                 input int sel, input int found,
                                                 input int w, input int h,
                                                 input int count, input int texels);
    level_result_t r;
    r.status = status;
    r.sel    = 4'(sel);
    r.found  = 1'(found);
    r.width  = SIDE_W'(w);
    r.height = SIDE_W'(h);
    r.count  = COUNT_W'(count);
    r.texels = TEXEL_W'(texels);
    return r;
  endfunction

  task automatic add_probe(input bit set_extent, input int w, input int h,
                           input int pw, input int ph, input int idx,
                           input bit typed, input level_result_t want);
    probe_row_t row;
    row.set_extent = set_extent;
    row.ext_w      = 15'(w);
    row.ext_h      = 15'(h);
    row.q.pw       = 16'(pw);
    row.q.ph       = 16'(ph);
    row.q.idx      = 4'(idx);
    row.typed      = typed;
    row.want       = want;
    probe_rows.insert(probe_rows.size(), row);
  endtask

  // Hold the sender off until every outstanding result has been checked.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes; the block must be idle when this is called.
  task automatic apply_extent(input bit set_w, input bit set_h,
                              input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
    if (set_w) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_WIDTH;
      cfg_data_i  <= w;
      @(posedge clk_i);
      disp_w = w;
      rebuild_chain();
    end
    if (set_h) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_HEIGHT;
      cfg_data_i  <= h;
      @(posedge clk_i);
      disp_h = h;
      rebuild_chain();
    end
    cfg_we_i <= 1'b0;
  endtask

  // Present one query, with a random gap before it, and record its answer.
  task automatic send_query(input level_query_t q, input bit typed,
                            input level_result_t want);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(q);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.insert(pending_results.size(), typed ? want : predict_level(q));
  endtask

  // Mostly valid display sides, with zero and above-ceiling sides mixed in.
  function automatic logic [SIDE_W-1:0] pick_side();
    case ($urandom_range(19))
      0:       return '0;
      1:       return SIDE_W'($urandom_range(32767, MAX_EXTENT + 1));
      2:       return SIDE_W'(MAX_EXTENT);
      3:       return SIDE_W'(1);
      4, 5, 6, 7, 8, 9: return SIDE_W'($urandom_range(64, 1));
      10, 11, 12, 13:   return SIDE_W'($urandom_range(1024, 1));
      default: return SIDE_W'($urandom_range(MAX_EXTENT, 1));
    endcase
  endfunction

  function automatic logic [PROJ_W-1:0] pick_proj();
    case ($urandom_range(7))
      0:       return PROJ_W'($urandom_range(3));
      1, 2:    return PROJ_W'($urandom_range(64));
      3:       return PROJ_W'($urandom_range(4096));
      4:       return '1;
      default: return PROJ_W'($urandom_range(65535));
    endcase
  endfunction

  // Result side: random backpressure and the scoreboard.
  always @(posedge clk_i) begin : result_check
    level_result_t got;
    level_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = level_result_t'(m_axis_tdata[70:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result transaction %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.sel !== want.sel ||
            got.found !== want.found || got.width !== want.width ||
            got.height !== want.height || got.count !== want.count ||
            got.texels !== want.texels) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: result mismatch");
            $display("  expected status %0d sel %0d found %0d w %0d h %0d cnt %0d tex %0d",
                     want.status, want.sel, want.found, want.width, want.height,
                     want.count, want.texels);
            $display("  actual   status %0d sel %0d found %0d w %0d h %0d cnt %0d tex %0d",
                     got.status, got.sel, got.found, got.width, got.height,
                     got.count, got.texels);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Stimulus: directed probes, then random phases under three idling mixes.
  initial begin : stimulus
    level_query_t  q;
    level_result_t zero_res;
    level_result_t above_res;
    int            sel_mode;

    zero_res  = typed_result(ST_ZERO, 0, 0, 0, 0, 0, 0);
    above_res = typed_result(ST_ABOVE, 0, 0, 0, 0, 0, 0);

    // No chain after reset.
    add_probe(0, 0, 0, 16'hFFFF, 16'hFFFF, 15, 1, zero_res);
    add_probe(0, 0, 0, 0, 0, 0, 1, zero_res);
    // Single 1x1 level: selection clamps to level 0.
    add_probe(1, 1, 1, 0, 0, 0, 1, typed_result(ST_OK, 0, 1, 1, 1, 1, 1));
    add_probe(0, 0, 0, 16'hFFFF, 16'hFFFF, 1, 1, typed_result(ST_OK, 0, 0, 0, 0, 1, 1));
    // Largest chain at the ceiling.
    add_probe(1, MAX_EXTENT, MAX_EXTENT, 0, 0, 0, 0, '0);
    add_probe(0, 0, 0, 16'hFFFF, 16'hFFFF, 14, 0, '0);
    add_probe(0, 0, 0, 3, 3, 15, 0, '0);
    add_probe(0, 0, 0, 2, 2, 0, 0, '0);
    add_probe(0, 0, 0, 3, 2, 7, 0, '0);
    // Refusals clear the chain that was there before.
    add_probe(1, MAX_EXTENT + 1, 100, 1, 1, 0, 1, above_res);
    add_probe(1, 32767, 32767, 16'hFFFF, 0, 15, 1, above_res);
    add_probe(1, 0, 5, 7, 7, 0, 1, zero_res);
    add_probe(1, 5, 0, 7, 7, 0, 1, zero_res);
    add_probe(1, MAX_EXTENT, MAX_EXTENT + 1, 9, 9, 1, 1, above_res);
    // Thin chains and ordinary sizes.
    add_probe(1, MAX_EXTENT, 1, 8, 1, 14, 0, '0);
    add_probe(1, 1, MAX_EXTENT, 1, 9, 3, 0, '0);
    add_probe(1, 1920, 1080, 100, 50, 4, 0, '0);
    add_probe(0, 0, 0, 16'hAAAA, 16'h5555, 10, 0, '0);
    add_probe(0, 0, 0, 16'h5555, 16'hAAAA, 5, 0, '0);
    add_probe(1, 3, 2, 5, 5, 2, 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].set_extent) begin
        wait_drained();
        apply_extent(1'b1, 1'b1, probe_rows[i].ext_w, probe_rows[i].ext_h);
      end
      send_query(probe_rows[i].q, probe_rows[i].typed, probe_rows[i].want);
    end

    for (int phase = 0; phase < 19; phase++) begin
      if (phase < 6) begin
        tx_idle_pct = 28;
        rx_idle_pct = 74;
      end else if (phase < 12) begin
        tx_idle_pct = 74;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // New extent: one side or both.
      wait_drained();
      sel_mode = $urandom_range(3);
      apply_extent(sel_mode != 1, sel_mode != 0, pick_side(), pick_side());
      for (int n = 0; n < 100; n++) begin
        if (phase == 3 && n == 50) wait_drained();
        q.pw  = pick_proj();
        q.ph  = pick_proj();
        q.idx = IDX_W'($urandom_range(15));
        send_query(q, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("depth_pyramid_level_select test passed");
    end else begin
      $display("depth_pyramid_level_select test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("depth_pyramid_level_select test failed");
    $finish;
  end

endmodule
